>>> rtl/core/phd_pkg.sv
package phd_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int CORDIC_STAGES = 18;

    // difference of two coordinates, and its magnitude
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int MAG_W  = COORD_WIDTH;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 1;

    // integer square root: one result bit per stage
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    // CORDIC datapath: x/y grow by the gain (< 2.33 with the quarter turn)
    localparam int CW     = DIFF_W + 3;
    localparam int ZW     = 34;
    localparam int ATAN_W = 30;

    localparam int HEAD_W = 19;
    localparam int DIST_W = ROOT_W;
    localparam int THR_W  = 16;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(7);

    localparam int HEAD_MAX    = 205887;
    localparam int HALF_PI_Q30 = 1686629713;
    localparam int ROUND_BIAS  = 8192;
    localparam int ANG_SHIFT   = 14;

    localparam logic signed [HEAD_W-1:0] HEAD_POS_MAX = HEAD_W'(HEAD_MAX);
    localparam logic signed [HEAD_W-1:0] HEAD_NEG_PI  = HEAD_W'(-HEAD_MAX);

    // stage counts after the difference register
    localparam int SQRT_LAT   = ROOT_W + 2;
    localparam int CORD_LAT   = CORDIC_STAGES + 2;
    localparam int HEAD_DELAY = SQRT_LAT - CORD_LAT;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
    } in_t;

    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        logic [DIST_W-1:0]        distance;
        logic                     coincident;
    } out_t;

    // atan(2^-i) in Q2.30
    function automatic logic [ATAN_W-1:0] atan_q30(input int unsigned i);
        logic [ATAN_W-1:0] v;
        case (i)
            0:       v = ATAN_W'(843314857);
            1:       v = ATAN_W'(497837829);
            2:       v = ATAN_W'(263043837);
            3:       v = ATAN_W'(133525159);
            4:       v = ATAN_W'(67021687);
            5:       v = ATAN_W'(33543516);
            6:       v = ATAN_W'(16775851);
            7:       v = ATAN_W'(8388437);
            8:       v = ATAN_W'(4194283);
            9:       v = ATAN_W'(2097149);
            10:      v = ATAN_W'(1048576);
            11:      v = ATAN_W'(524288);
            12:      v = ATAN_W'(262144);
            13:      v = ATAN_W'(131072);
            14:      v = ATAN_W'(65536);
            15:      v = ATAN_W'(32768);
            16:      v = ATAN_W'(16384);
            17:      v = ATAN_W'(8192);
            18:      v = ATAN_W'(4096);
            19:      v = ATAN_W'(2048);
            20:      v = ATAN_W'(1024);
            21:      v = ATAN_W'(512);
            22:      v = ATAN_W'(256);
            23:      v = ATAN_W'(128);
            24:      v = ATAN_W'(64);
            25:      v = ATAN_W'(32);
            26:      v = ATAN_W'(16);
            27:      v = ATAN_W'(8);
            28:      v = ATAN_W'(4);
            29:      v = ATAN_W'(2);
            30:      v = ATAN_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/phd_diff_sq.sv
module phd_diff_sq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  phd_pkg::in_t                       in_data,
    output logic signed [phd_pkg::DIFF_W-1:0]  dx,
    output logic signed [phd_pkg::DIFF_W-1:0]  dy,
    output logic                               sum_valid,
    output logic [phd_pkg::SUM_W-1:0]          sum
);

    logic signed [phd_pkg::DIFF_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [phd_pkg::MAG_W-1:0]         mx, my;
    logic [phd_pkg::SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [phd_pkg::SUM_W-1:0]         sum_reg;
    logic                              va_reg, vb_reg, vc_reg;

    assign dx_next = phd_pkg::DIFF_W'(in_data.bx) - phd_pkg::DIFF_W'(in_data.ax);
    assign dy_next = phd_pkg::DIFF_W'(in_data.by) - phd_pkg::DIFF_W'(in_data.ay);

    // |d| never exceeds 2^COORD_WIDTH - 1, so it fits MAG_W bits
    assign mx = dx_reg[phd_pkg::DIFF_W-1] ? phd_pkg::MAG_W'(-dx_reg) : phd_pkg::MAG_W'(dx_reg);
    assign my = dy_reg[phd_pkg::DIFF_W-1] ? phd_pkg::MAG_W'(-dy_reg) : phd_pkg::MAG_W'(dy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            sqx_reg <= phd_pkg::SQ_W'(mx) * phd_pkg::SQ_W'(mx);
            sqy_reg <= phd_pkg::SQ_W'(my) * phd_pkg::SQ_W'(my);
            sum_reg <= phd_pkg::SUM_W'(sqx_reg) + phd_pkg::SUM_W'(sqy_reg);
        end
    end

    assign dx        = dx_reg;
    assign dy        = dy_reg;
    assign sum_valid = vc_reg;
    assign sum       = sum_reg;

endmodule

>>> rtl/core/phd_isqrt.sv
module phd_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [phd_pkg::SUM_W-1:0]    sum,
    output logic                         out_valid,
    output logic [phd_pkg::ROOT_W-1:0]   root
);

    localparam int N = phd_pkg::ROOT_W;

    logic                        valid_reg [N];
    logic [phd_pkg::ROOT_W-1:0]  root_reg  [N];
    logic [phd_pkg::REM_W-1:0]   rem_reg   [N-1];
    logic [phd_pkg::RAD_W-1:0]   rad_reg   [N-1];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [phd_pkg::REM_W-1:0]  rem_in, cur, trial;
        logic [phd_pkg::ROOT_W-1:0] root_in;
        logic [phd_pkg::RAD_W-1:0]  rad_in;
        logic                       v_in, ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = phd_pkg::RAD_W'(sum);
            assign v_in    = in_valid;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign v_in    = valid_reg[k-1];
        end

        // bring down the next pair of radicand bits, try root*4+1
        assign cur   = {rem_in[phd_pkg::REM_W-3:0], rad_in[phd_pkg::RAD_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                root_reg[k] <= {root_in[phd_pkg::ROOT_W-2:0], ge};
        end

        if (k < N - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? cur - trial : cur;
                    rad_reg[k] <= rad_in << 2;
                end
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign root      = root_reg[N-1];

endmodule

>>> rtl/core/phd_cordic.sv
module phd_cordic (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [phd_pkg::DIFF_W-1:0]  dx,
    input  logic signed [phd_pkg::DIFF_W-1:0]  dy,
    output logic signed [phd_pkg::HEAD_W-1:0]  heading
);

    localparam int S = phd_pkg::CORDIC_STAGES;
    localparam int CW = phd_pkg::CW;
    localparam int ZW = phd_pkg::ZW;

    localparam logic signed [ZW-1:0] Z_HALF_PI = ZW'(phd_pkg::HALF_PI_Q30);
    localparam logic signed [ZW-1:0] Z_MAX     = ZW'(phd_pkg::HEAD_MAX);
    localparam logic signed [ZW-1:0] Z_MIN     = ZW'(-phd_pkg::HEAD_MAX);
    localparam logic signed [ZW-1:0] Z_BIAS    = ZW'(phd_pkg::ROUND_BIAS);

    logic signed [CW-1:0] x_reg [S];
    logic signed [CW-1:0] y_reg [S];
    logic signed [ZW-1:0] z_reg [S+1];
    logic                 back_reg [S+1];

    logic signed [CW-1:0]                x0, y0, dxw, dyw;
    logic signed [ZW-1:0]                z0, zr, zq;
    logic signed [phd_pkg::HEAD_W-1:0]   head_reg, head_next;
    logic                                dx_neg;

    assign dxw    = CW'(dx);
    assign dyw    = CW'(dy);
    assign dx_neg = dx[phd_pkg::DIFF_W-1];

    // quarter turn into the right half plane
    always_comb
    begin
        x0 = dxw;
        y0 = dyw;
        z0 = '0;
        if (dx_neg)
        begin
            if (!dy[phd_pkg::DIFF_W-1] && dy != '0)
            begin
                x0 = dyw;
                y0 = -dxw;
                z0 = Z_HALF_PI;
            end
            else
            begin
                x0 = -dyw;
                y0 = dxw;
                z0 = -Z_HALF_PI;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0;
            y_reg[0]    <= y0;
            z_reg[0]    <= z0;
            back_reg[0] <= dx_neg && dy == '0;
        end
    end

    for (genvar i = 0; i < S; i++)
    begin : g_rot
        localparam logic signed [ZW-1:0] ATAN =
            ZW'({1'b0, phd_pkg::atan_q30(i)});
        logic dir;

        // y == 0 rotates clockwise
        assign dir = !y_reg[i][CW-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z_reg[i+1]    <= dir ? z_reg[i] + ATAN : z_reg[i] - ATAN;
                back_reg[i+1] <= back_reg[i];
            end
        end

        if (i < S - 1)
        begin : g_xy
            logic signed [CW-1:0] xs, ys;
            assign xs = x_reg[i] >>> i;
            assign ys = y_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i+1] <= dir ? x_reg[i] + ys : x_reg[i] - ys;
                    y_reg[i+1] <= dir ? y_reg[i] - xs : y_reg[i] + xs;
                end
            end
        end
    end

    // Q2.30 to Q2.16, round half up, clamp
    assign zr = z_reg[S] + Z_BIAS;
    assign zq = zr >>> phd_pkg::ANG_SHIFT;

    always_comb
    begin
        if (back_reg[S])
            head_next = phd_pkg::HEAD_NEG_PI;
        else if (zq > Z_MAX)
            head_next = phd_pkg::HEAD_POS_MAX;
        else if (zq < Z_MIN)
            head_next = phd_pkg::HEAD_NEG_PI;
        else
            head_next = zq[phd_pkg::HEAD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            head_reg <= head_next;
    end

    assign heading = head_reg;

endmodule

>>> rtl/core/planar_heading_and_distance.sv
// Planar heading and distance.
// in channel (in_valid/in_ready/in_data): one beat carries points a and b,
// signed Q15.16. out channel (out_valid/out_ready/out_data): one beat per
// input beat, in order, with the Q17.16 distance, the Q2.16 heading from a
// to b in [-pi, pi] and the coincident flag.
// cfg channel (cfg_valid/cfg_ready/cfg_data): writes the 16-bit dead-zone
// threshold; cfg_ready is always high. Write it only while the block is idle.
// Throughput: one beat per cycle. The path to out_valid runs through the
// difference, square and sum stages, then the 33-stage square-root
// pipeline (one root bit per stage), then the output register.
// The 18-stage CORDIC runs alongside and its heading is delayed to match.
// Reset clears every valid bit and loads the threshold with 7.
// When out_ready is low while out_valid is high, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated.
module planar_heading_and_distance (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  phd_pkg::in_t                in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output phd_pkg::out_t               out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [phd_pkg::THR_W-1:0]   cfg_data
);

    logic                               en;
    logic signed [phd_pkg::DIFF_W-1:0]  dx, dy;
    logic                               sum_valid, root_valid;
    logic [phd_pkg::SUM_W-1:0]          sum;
    logic [phd_pkg::ROOT_W-1:0]         root;
    logic signed [phd_pkg::HEAD_W-1:0]  cordic_head;
    logic signed [phd_pkg::HEAD_W-1:0]  head_dly_reg [phd_pkg::HEAD_DELAY];
    logic [phd_pkg::THR_W-1:0]          thr_reg;
    logic                               out_valid_reg;
    phd_pkg::out_t                      out_reg, out_next;
    logic                               near;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= phd_pkg::THR_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    phd_diff_sq u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .dx        (dx),
        .dy        (dy),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    phd_isqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sum_valid),
        .sum       (sum),
        .out_valid (root_valid),
        .root      (root)
    );

    phd_cordic u_cordic (
        .clk     (clk),
        .en      (en),
        .dx      (dx),
        .dy      (dy),
        .heading (cordic_head)
    );

    // line the heading up with the root
    always_ff @(posedge clk)
    begin
        if (en)
            head_dly_reg[0] <= cordic_head;
    end

    for (genvar k = 1; k < phd_pkg::HEAD_DELAY; k++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
                head_dly_reg[k] <= head_dly_reg[k-1];
        end
    end

    assign near = root <= phd_pkg::ROOT_W'(thr_reg);

    always_comb
    begin
        out_next.distance   = root;
        out_next.coincident = near;
        out_next.heading    = near ? '0 : head_dly_reg[phd_pkg::HEAD_DELAY-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= root_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> rtl/core/phd_checker.sv
module phd_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  phd_pkg::in_t                in_data,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  phd_pkg::out_t               out_data,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [phd_pkg::THR_W-1:0]   cfg_data
);

    // a coincident result carries a zero heading
    a_coincident_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.coincident |-> out_data.heading == '0)
        else $error("coincident beat with non-zero heading");

    // zero distance is always inside the dead zone
    a_zero_dist_near: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.distance == '0 |-> out_data.coincident)
        else $error("zero distance not flagged coincident");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.heading >= phd_pkg::HEAD_NEG_PI
                   && out_data.heading <= phd_pkg::HEAD_POS_MAX)
        else $error("heading out of range");

    // with no beat waiting at the output the pipeline must take input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

endmodule

bind planar_heading_and_distance phd_checker u_phd_checker (.*);
